// ===== design/tgc_pkg.sv =====
// Shared types and constants of the tile gradient coherence block.
// Used by the channel interfaces, the top level and nothing else; no dependencies.
package tgc_pkg;

   localparam int GRAD_BITS = 13;
   localparam int CFG_BITS = 13;
   localparam int CSR_IDX_BITS = 2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_WIDTH = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WINDOW_SIZE = 2'd2;

   localparam int WIN_BITS = 7;
   localparam int MAX_WINDOW = 64;
   localparam int TILE_CNT_BITS = 6;
   localparam int ROW_BITS = 12;
   localparam int MAX_ROWS = 4096;
   localparam int LIM_BITS = 14;
   localparam int OUT_IDX_BITS = 12;

   localparam int SQ_BITS = 2 * GRAD_BITS;
   localparam int MAG_BITS = SQ_BITS + 1;
   localparam int EDGE_MAG_SQ = 4096;

   localparam int RUN_EDGE_BITS = 7;
   localparam int RUN_SQ_BITS = 31;
   localparam int RUN_XY_BITS = 32;
   localparam int ST_EDGE_BITS = 13;
   localparam int ST_SQ_BITS = 37;
   localparam int ST_XY_BITS = 38;

   localparam int AREA_BITS = 20;
   localparam int AREA_PCT = 42;
   localparam int PCT_SCALE = 100;

   localparam int OP_BITS = 39;
   localparam int PROD_BITS = 2 * OP_BITS;
   localparam int CMP_BITS = PROD_BITS + 8;

   localparam int CORDIC_STEPS = 16;
   localparam int STEP_BITS = 4;
   localparam int CX_BITS = 42;
   localparam int Z_BITS = 20;
   localparam int HALF_PI_Q16 = 102944;
   localparam int ORIENT_LIMIT = 25736;
   localparam int ORIENT_BITS = 16;

   typedef struct packed {
      logic [ST_EDGE_BITS-1:0] edges;
      logic [ST_SQ_BITS-1:0] xx;
      logic [ST_SQ_BITS-1:0] yy;
      logic signed [ST_XY_BITS-1:0] xy;
   } col_sum_type;

   localparam int ENTRY_BITS = $bits(col_sum_type);

   // atan(2^-i) in units of 2^-16 radian.
   function automatic logic signed [Z_BITS-1:0] atan_q16(input logic [STEP_BITS-1:0] i);
      logic signed [Z_BITS-1:0] r;
      case (i)
         4'd0: r = 20'sd51472;
         4'd1: r = 20'sd30386;
         4'd2: r = 20'sd16055;
         4'd3: r = 20'sd8150;
         4'd4: r = 20'sd4091;
         4'd5: r = 20'sd2047;
         4'd6: r = 20'sd1024;
         4'd7: r = 20'sd512;
         4'd8: r = 20'sd256;
         4'd9: r = 20'sd128;
         4'd10: r = 20'sd64;
         4'd11: r = 20'sd32;
         4'd12: r = 20'sd16;
         4'd13: r = 20'sd8;
         4'd14: r = 20'sd4;
         default: r = 20'sd2;
      endcase
      return r;
   endfunction

endpackage

// ===== design/tgc_if.sv =====
// Valid/ready channel interfaces for gradient items and tile result items.
// Depends on tgc_pkg for the field widths.
interface tgc_req_if;
   logic valid;
   logic ready;
   logic signed [tgc_pkg::GRAD_BITS-1:0] grad_x;
   logic signed [tgc_pkg::GRAD_BITS-1:0] grad_y;
   logic frame_start;
   modport source(output valid, grad_x, grad_y, frame_start, input ready);
   modport sink(input valid, grad_x, grad_y, frame_start, output ready);
endinterface

interface tgc_rsp_if;
   logic valid;
   logic ready;
   logic [tgc_pkg::OUT_IDX_BITS-1:0] tile_col;
   logic [tgc_pkg::OUT_IDX_BITS-1:0] tile_row;
   logic coherent;
   logic signed [tgc_pkg::ORIENT_BITS-1:0] orientation;
   logic [tgc_pkg::ST_EDGE_BITS-1:0] edge_count;
   modport source(output valid, tile_col, tile_row, coherent, orientation, edge_count,
                  input ready);
   modport sink(input valid, tile_col, tile_row, coherent, orientation, edge_count,
                output ready);
endinterface

// ===== design/tile_gradient_coherence.sv =====
// Tile gradient coherence: takes raster-order gradient items and emits one result item
// per full window-by-window tile (tile position, coherence flag, half atan2 orientation
// in Q2.14 radians and edge count). Depends on tgc_pkg, tgc_if and tgc_ram.
//
// An item that does not close a row segment of a tile passes through S_IDLE and S_PIX.
// An item that closes a segment adds a restoring divider for the tile position (S_DIV)
// and a read-modify-write of the column sum RAM (S_RD, S_WB). An item that closes a
// tile adds the coherence test, built on bit-serial squaring (S_PREP to S_DEC), and for
// a coherent tile the 16-step CORDIC (S_CROT, S_CORD, S_RND).
// A finished result waits in an output register, so items are taken while it is unread;
// a second tile finishing before the first result is taken holds the input.
module tile_gradient_coherence #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic clock,
   input  logic reset,
   tgc_req_if.sink req_ch,
   tgc_rsp_if.source rsp_ch,
   input  logic                                csr_we,
   input  logic [tgc_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [tgc_pkg::CFG_BITS-1:0]        csr_wdata
);
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = tgc_pkg::ROW_BITS;
   localparam int DIVW = (CW > RW) ? CW : RW;
   localparam int DCW = $clog2(DIVW);
   localparam int WB = tgc_pkg::WIN_BITS;
   localparam int TB = tgc_pkg::TILE_CNT_BITS;
   localparam int LB = tgc_pkg::LIM_BITS;
   localparam int GB = tgc_pkg::GRAD_BITS;
   localparam int SB = tgc_pkg::SQ_BITS;
   localparam int OB = tgc_pkg::OP_BITS;
   localparam int MKW = $clog2(OB);
   localparam int PB = tgc_pkg::PROD_BITS;
   localparam int KB = tgc_pkg::CMP_BITS;
   localparam int XB = tgc_pkg::CX_BITS;
   localparam int ZB = tgc_pkg::Z_BITS;
   localparam int ST_XY_TOP = tgc_pkg::ST_XY_BITS - 1;

   typedef enum logic [3:0] {
      S_IDLE, S_PIX, S_DIV, S_RD, S_WB, S_PREP, S_MUL, S_SUM, S_SCL, S_DEC,
      S_CROT, S_CORD, S_RND, S_OUT
   } state_type;

   state_type state_ff;

   // Configuration registers.
   logic [tgc_pkg::CFG_BITS-1:0] image_width_ff, image_height_ff;
   logic [WB-1:0] window_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff <= 13'd512;
         image_height_ff <= 13'd512;
         window_size_ff <= 7'd8;
      end else if (csr_we) begin
         case (csr_index)
            tgc_pkg::CSR_IMAGE_WIDTH: image_width_ff <= csr_wdata;
            tgc_pkg::CSR_IMAGE_HEIGHT: image_height_ff <= csr_wdata;
            tgc_pkg::CSR_WINDOW_SIZE: window_size_ff <= csr_wdata[WB-1:0];
            default: ;
         endcase
      end
   end

   // Limits with out-of-range settings folded into range.
   logic [LB-1:0] w_eff;
   logic [tgc_pkg::CFG_BITS-1:0] h_eff;
   logic [WB-1:0] win_eff;

   always_comb begin
      if (image_width_ff == '0) w_eff = LB'(1);
      else if (LB'(image_width_ff) > LB'(MAX_WIDTH)) w_eff = LB'(MAX_WIDTH);
      else w_eff = LB'(image_width_ff);
      if (image_height_ff == '0) h_eff = 13'd1;
      else if (image_height_ff > 13'(tgc_pkg::MAX_ROWS)) h_eff = 13'(tgc_pkg::MAX_ROWS);
      else h_eff = image_height_ff;
      if (window_size_ff == '0) win_eff = WB'(1);
      else if (window_size_ff > WB'(tgc_pkg::MAX_WINDOW)) win_eff = WB'(tgc_pkg::MAX_WINDOW);
      else win_eff = window_size_ff;
   end

   // Pixel position and row segment sums.
   logic [CW-1:0] pixel_col_ff, pixel_col_in;
   logic [RW-1:0] pixel_row_ff, pixel_row_in;
   logic [TB-1:0] col_in_tile_ff, col_in_tile_in, row_in_tile_ff, row_in_tile_in;
   logic [tgc_pkg::RUN_EDGE_BITS-1:0] run_edge_ff, run_edge_in, seg_edge_ff;
   logic [tgc_pkg::RUN_SQ_BITS-1:0] run_xx_ff, run_xx_in, run_yy_ff, run_yy_in;
   logic [tgc_pkg::RUN_SQ_BITS-1:0] seg_xx_ff, seg_yy_ff;
   logic signed [tgc_pkg::RUN_XY_BITS-1:0] run_xy_ff, run_xy_in, seg_xy_ff;

   logic signed [GB-1:0] gx_ff, gy_ff;
   logic fs_ff;
   logic first_row_ff, tile_end_ff;

   logic [CW-1:0] pc;
   logic [RW-1:0] pr;
   logic [TB-1:0] cit, rit;
   logic signed [SB-1:0] prod_x, prod_y, prod_xy;
   logic [tgc_pkg::MAG_BITS-1:0] mag;
   logic is_edge, seg_end, row_end, tile_end;
   logic [tgc_pkg::RUN_EDGE_BITS-1:0] sum_edge;
   logic [tgc_pkg::RUN_SQ_BITS-1:0] sum_xx, sum_yy;
   logic signed [tgc_pkg::RUN_XY_BITS-1:0] sum_xy;

   always_comb begin
      pc = fs_ff ? '0 : pixel_col_ff;
      pr = fs_ff ? '0 : pixel_row_ff;
      cit = fs_ff ? '0 : col_in_tile_ff;
      rit = fs_ff ? '0 : row_in_tile_ff;
      prod_x = gx_ff * gx_ff;
      prod_y = gy_ff * gy_ff;
      prod_xy = gx_ff * gy_ff;
      mag = {1'b0, prod_x} + {1'b0, prod_y};
      is_edge = mag > tgc_pkg::MAG_BITS'(tgc_pkg::EDGE_MAG_SQ);
      sum_edge = (fs_ff ? '0 : run_edge_ff) + (is_edge ? 7'd1 : 7'd0);
      sum_xx = (fs_ff ? '0 : run_xx_ff)
               + (is_edge ? tgc_pkg::RUN_SQ_BITS'(unsigned'(prod_x)) : '0);
      sum_yy = (fs_ff ? '0 : run_yy_ff)
               + (is_edge ? tgc_pkg::RUN_SQ_BITS'(unsigned'(prod_y)) : '0);
      sum_xy = (fs_ff ? '0 : run_xy_ff)
               + (is_edge ? tgc_pkg::RUN_XY_BITS'(prod_xy) : '0);
      seg_end = ({1'b0, cit} + 7'd1) >= win_eff;
      tile_end = ({1'b0, rit} + 7'd1) >= win_eff;
      row_end = (LB'(pc) + LB'(1)) >= w_eff;

      col_in_tile_in = seg_end ? '0 : cit + TB'(1);
      pixel_col_in = pc + CW'(1);
      pixel_row_in = pr;
      row_in_tile_in = rit;
      if (row_end) begin
         pixel_col_in = '0;
         col_in_tile_in = '0;
         if ((13'(pr) + 13'd1) >= h_eff) begin
            pixel_row_in = '0;
            row_in_tile_in = '0;
         end else begin
            pixel_row_in = pr + RW'(1);
            row_in_tile_in = tile_end ? '0 : rit + TB'(1);
         end
      end
      if (seg_end || row_end) begin
         run_edge_in = '0;
         run_xx_in = '0;
         run_yy_in = '0;
         run_xy_in = '0;
      end else begin
         run_edge_in = sum_edge;
         run_xx_in = sum_xx;
         run_yy_in = sum_yy;
         run_xy_in = sum_xy;
      end
   end

   // Tile position dividers: the dividend register turns into the quotient.
   logic [DIVW-1:0] div_col_ff, div_row_ff;
   logic [WB-1:0] rem_col_ff, rem_row_ff;
   logic [DCW-1:0] div_cnt_ff;
   logic [WB:0] rc_col, rc_row;
   logic qb_col, qb_row;

   always_comb begin
      rc_col = {rem_col_ff, div_col_ff[DIVW-1]};
      rc_row = {rem_row_ff, div_row_ff[DIVW-1]};
      qb_col = rc_col >= {1'b0, win_eff};
      qb_row = rc_row >= {1'b0, win_eff};
   end

   // Column sum memory.
   logic ram_we;
   tgc_pkg::col_sum_type rd_sum, wb_sum, sum_ff;

   tgc_ram #(.WIDTH(tgc_pkg::ENTRY_BITS), .DEPTH(MAX_WIDTH)) u_col_ram (
      .clock(clock),
      .we(ram_we),
      .waddr(div_col_ff[CW-1:0]),
      .wdata(wb_sum),
      .raddr(div_col_ff[CW-1:0]),
      .rdata(rd_sum)
   );

   always_comb begin
      ram_we = state_ff == S_WB;
      wb_sum.edges = 13'(seg_edge_ff) + (first_row_ff ? '0 : rd_sum.edges);
      wb_sum.xx = 37'(seg_xx_ff) + (first_row_ff ? '0 : rd_sum.xx);
      wb_sum.yy = 37'(seg_yy_ff) + (first_row_ff ? '0 : rd_sum.yy);
      wb_sum.xy = 38'(seg_xy_ff) + (first_row_ff ? '0 : rd_sum.xy);
   end

   // Coherence test operands and bit-serial squares.
   logic [OB-1:0] op_d_ff, op_c_ff, op_s_ff;
   logic [PB-1:0] acc_d_ff, acc_c_ff, acc_s_ff;
   logic [MKW-1:0] mul_k_ff;
   logic [PB:0] psum_ff;
   logic [KB-1:0] lhs_ff, rhs_ff;

   logic [tgc_pkg::ST_SQ_BITS-1:0] d_abs;
   logic [tgc_pkg::ST_XY_BITS-1:0] c_abs;
   logic [tgc_pkg::AREA_BITS-1:0] area_have, area_need;
   logic area_ok;

   always_comb begin
      d_abs = (sum_ff.xx >= sum_ff.yy) ? sum_ff.xx - sum_ff.yy : sum_ff.yy - sum_ff.xx;
      c_abs = sum_ff.xy[ST_XY_TOP] ? unsigned'(-sum_ff.xy) : unsigned'(sum_ff.xy);
      area_have = tgc_pkg::AREA_BITS'(sum_ff.edges) * tgc_pkg::AREA_BITS'(tgc_pkg::PCT_SCALE);
      area_need = tgc_pkg::AREA_BITS'(win_eff) * tgc_pkg::AREA_BITS'(win_eff)
                  * tgc_pkg::AREA_BITS'(tgc_pkg::AREA_PCT);
      area_ok = area_have >= area_need;
   end

   // CORDIC vectoring.
   logic signed [XB-1:0] cx_ff, cy_ff, x0, y0, dx, dy;
   logic signed [ZB-1:0] cz_ff, zr;
   logic [tgc_pkg::STEP_BITS-1:0] step_ff;

   always_comb begin
      x0 = XB'(signed'({sum_ff.xy, 1'b0}));
      y0 = XB'(signed'({1'b0, sum_ff.xx})) - XB'(signed'({1'b0, sum_ff.yy}));
      dx = cy_ff >>> step_ff;
      dy = cx_ff >>> step_ff;
      zr = (cz_ff + ZB'(4)) >>> 3;
   end

   // Result register.
   logic rsp_valid_ff, coh_ff;
   logic signed [tgc_pkg::ORIENT_BITS-1:0] orient_ff, orient_out_ff;
   logic [tgc_pkg::OUT_IDX_BITS-1:0] tile_col_ff, tile_row_ff;
   logic [tgc_pkg::OUT_IDX_BITS-1:0] rsp_col_ff, rsp_row_ff;
   logic coh_out_ff;
   logic [tgc_pkg::ST_EDGE_BITS-1:0] edge_out_ff;
   logic out_load;

   assign out_load = state_ff == S_OUT && (!rsp_valid_ff || rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         pixel_col_ff <= '0;
         pixel_row_ff <= '0;
         col_in_tile_ff <= '0;
         row_in_tile_ff <= '0;
         run_edge_ff <= '0;
         run_xx_ff <= '0;
         run_yy_ff <= '0;
         run_xy_ff <= '0;
         div_cnt_ff <= '0;
         mul_k_ff <= '0;
         step_ff <= '0;
         coh_ff <= 1'b0;
      end else begin
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_ch.valid) begin
                  gx_ff <= req_ch.grad_x;
                  gy_ff <= req_ch.grad_y;
                  fs_ff <= req_ch.frame_start;
                  state_ff <= S_PIX;
               end
            end
            S_PIX: begin
               pixel_col_ff <= pixel_col_in;
               pixel_row_ff <= pixel_row_in;
               col_in_tile_ff <= col_in_tile_in;
               row_in_tile_ff <= row_in_tile_in;
               run_edge_ff <= run_edge_in;
               run_xx_ff <= run_xx_in;
               run_yy_ff <= run_yy_in;
               run_xy_ff <= run_xy_in;
               seg_edge_ff <= sum_edge;
               seg_xx_ff <= sum_xx;
               seg_yy_ff <= sum_yy;
               seg_xy_ff <= sum_xy;
               first_row_ff <= rit == '0;
               tile_end_ff <= tile_end;
               div_col_ff <= DIVW'(pc);
               div_row_ff <= DIVW'(pr);
               rem_col_ff <= '0;
               rem_row_ff <= '0;
               div_cnt_ff <= '0;
               state_ff <= seg_end ? S_DIV : S_IDLE;
            end
            S_DIV: begin
               rem_col_ff <= qb_col ? WB'(rc_col - {1'b0, win_eff}) : rc_col[WB-1:0];
               rem_row_ff <= qb_row ? WB'(rc_row - {1'b0, win_eff}) : rc_row[WB-1:0];
               div_col_ff <= {div_col_ff[DIVW-2:0], qb_col};
               div_row_ff <= {div_row_ff[DIVW-2:0], qb_row};
               div_cnt_ff <= div_cnt_ff + DCW'(1);
               if (div_cnt_ff == DCW'(DIVW - 1)) begin
                  state_ff <= S_RD;
               end
            end
            S_RD: begin
               state_ff <= S_WB;
            end
            S_WB: begin
               sum_ff <= wb_sum;
               tile_col_ff <= div_col_ff[tgc_pkg::OUT_IDX_BITS-1:0];
               tile_row_ff <= div_row_ff[tgc_pkg::OUT_IDX_BITS-1:0];
               state_ff <= tile_end_ff ? S_PREP : S_IDLE;
            end
            S_PREP: begin
               op_d_ff <= OB'(d_abs);
               op_c_ff <= {c_abs, 1'b0};
               op_s_ff <= OB'(sum_ff.xx) + OB'(sum_ff.yy);
               acc_d_ff <= '0;
               acc_c_ff <= '0;
               acc_s_ff <= '0;
               mul_k_ff <= MKW'(OB - 1);
               coh_ff <= 1'b0;
               state_ff <= area_ok ? S_MUL : S_OUT;
            end
            S_MUL: begin
               acc_d_ff <= {acc_d_ff[PB-2:0], 1'b0} + (op_d_ff[mul_k_ff] ? PB'(op_d_ff) : '0);
               acc_c_ff <= {acc_c_ff[PB-2:0], 1'b0} + (op_c_ff[mul_k_ff] ? PB'(op_c_ff) : '0);
               acc_s_ff <= {acc_s_ff[PB-2:0], 1'b0} + (op_s_ff[mul_k_ff] ? PB'(op_s_ff) : '0);
               mul_k_ff <= mul_k_ff - 1'b1;
               if (mul_k_ff == '0) begin
                  state_ff <= S_SUM;
               end
            end
            S_SUM: begin
               psum_ff <= (PB + 1)'(acc_d_ff) + (PB + 1)'(acc_c_ff);
               state_ff <= S_SCL;
            end
            S_SCL: begin
               // 100 = 64 + 32 + 4 and 81 = 64 + 16 + 1.
               lhs_ff <= (KB'(psum_ff) << 6) + (KB'(psum_ff) << 5) + (KB'(psum_ff) << 2);
               rhs_ff <= (KB'(acc_s_ff) << 6) + (KB'(acc_s_ff) << 4) + KB'(acc_s_ff);
               state_ff <= S_DEC;
            end
            S_DEC: begin
               state_ff <= (lhs_ff > rhs_ff) ? S_CROT : S_OUT;
            end
            S_CROT: begin
               // Fold the left half plane onto the right before the rotations.
               if (x0 < 0) begin
                  if (y0 >= 0) begin
                     cx_ff <= y0;
                     cy_ff <= -x0;
                     cz_ff <= ZB'(tgc_pkg::HALF_PI_Q16);
                  end else begin
                     cx_ff <= -y0;
                     cy_ff <= x0;
                     cz_ff <= -ZB'(tgc_pkg::HALF_PI_Q16);
                  end
               end else begin
                  cx_ff <= x0;
                  cy_ff <= y0;
                  cz_ff <= '0;
               end
               step_ff <= '0;
               state_ff <= S_CORD;
            end
            S_CORD: begin
               if (cy_ff > 0) begin
                  cx_ff <= cx_ff + dx;
                  cy_ff <= cy_ff - dy;
                  cz_ff <= cz_ff + tgc_pkg::atan_q16(step_ff);
               end else begin
                  cx_ff <= cx_ff - dx;
                  cy_ff <= cy_ff + dy;
                  cz_ff <= cz_ff - tgc_pkg::atan_q16(step_ff);
               end
               step_ff <= step_ff + 1'b1;
               if (step_ff == tgc_pkg::STEP_BITS'(tgc_pkg::CORDIC_STEPS - 1)) begin
                  state_ff <= S_RND;
               end
            end
            S_RND: begin
               if (zr > ZB'(tgc_pkg::ORIENT_LIMIT)) begin
                  orient_ff <= tgc_pkg::ORIENT_BITS'(tgc_pkg::ORIENT_LIMIT);
               end else if (zr < -ZB'(tgc_pkg::ORIENT_LIMIT)) begin
                  orient_ff <= -tgc_pkg::ORIENT_BITS'(tgc_pkg::ORIENT_LIMIT);
               end else begin
                  orient_ff <= zr[tgc_pkg::ORIENT_BITS-1:0];
               end
               coh_ff <= 1'b1;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (out_load) begin
                  coh_out_ff <= coh_ff;
                  orient_out_ff <= coh_ff ? orient_ff : '0;
                  edge_out_ff <= coh_ff ? sum_ff.edges : '0;
                  rsp_col_ff <= tile_col_ff;
                  rsp_row_ff <= tile_row_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ch.ready = state_ff == S_IDLE;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.tile_col = rsp_col_ff;
   assign rsp_ch.tile_row = rsp_row_ff;
   assign rsp_ch.coherent = coh_out_ff;
   assign rsp_ch.orientation = orient_out_ff;
   assign rsp_ch.edge_count = edge_out_ff;

   // An incoherent tile reports neither angle nor count.
   a_incoherent_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !coh_out_ff) |-> (orient_out_ff == '0 && edge_out_ff == '0))
      else $error("incoherent tile carries orientation or count");

   // A finished tile waits while the previous result is still untaken.
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && rsp_valid_ff && !rsp_ch.ready) |=> (state_ff == S_OUT))
      else $error("result overwritten before it was taken");

   // An accepted item is processed in the next cycle.
   a_accept_pix: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> (state_ff == S_PIX))
      else $error("accepted item not processed");

   // The reported angle stays within the clamp.
   a_orient_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (orient_out_ff <= 16'sd25736 && orient_out_ff >= -16'sd25736))
      else $error("orientation out of range");
endmodule

// ===== design/tgc_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module tgc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule
